@@ rtl/core/sprite_animation_sequencer_unit_macros.svh @@
// assertion macros for the sprite animation sequencer
`ifndef SPRITE_ANIMATION_SEQUENCER_UNIT_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sas_pkg.sv @@
// shared types, register codes and clip table lookups for the sequencer
package sas_pkg;

    // request kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TICK     = 2'd0;
    localparam t_kind KIND_SEL_CUR  = 2'd1;
    localparam t_kind KIND_SEL_DEF  = 2'd2;

    // configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_FRAME_RATE    = 3'd0;
    localparam t_cfg_index CFG_CLIP_LENGTHS  = 3'd1;
    localparam t_cfg_index CFG_ONCE_MASK     = 3'd2;
    localparam t_cfg_index CFG_NEXT_TABLE    = 3'd3;
    localparam t_cfg_index CFG_TEX_BASES     = 3'd4;
    localparam t_cfg_index CFG_CLIP_COUNT    = 3'd5;

    // remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_status;

    // per-clip field lookups
    function automatic logic [7:0] clip_len(input logic [63:0] tbl, input logic [2:0] c);
        clip_len = tbl[{c, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] clip_base(input logic [63:0] tbl, input logic [2:0] c);
        clip_base = tbl[{c, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] clip_next(input logic [31:0] tbl, input logic [2:0] c);
        clip_next = tbl[{c, 2'b00} +: 4];
    endfunction

    function automatic logic clip_once(input logic [7:0] mask, input logic [2:0] c);
        clip_once = mask[c];
    endfunction

endpackage

@@ rtl/core/sprite_animation_sequencer_unit.sv @@
// sprite animation sequencer: clip table, frame position and request sequencer
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+------------------------------------------
//   request   | i_in_valid / o_in_stall   | i_kind, i_delta, i_clip_index
//   result    | o_out_valid / i_out_stall | o_texture_index, o_current_clip,
//             |                           | o_frame_number, o_finished, o_change_accepted
//   config    | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// selects, zero-length ticks, chains and restarts go straight to the done state;
// an advancing tick passes the multiply, add, check and texture states, and the divide and
// wrap states when a loop clip wraps (bit-serial remainder of INT_W = 17 bits at FRAC_BITS = 8).
// one request at a time: o_in_stall is high from acceptance until the result is loaded.
// a waiting result holds while i_out_stall is high; the next request is taken meanwhile.
// synchronous active-low reset restores the register defaults and clears the control state.
module sprite_animation_sequencer_unit #(
    parameter int MAX_CLIPS = 8,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sas_pkg::t_kind       i_kind,
    input  logic [15:0]          i_delta,
    input  logic [2:0]           i_clip_index,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_texture_index,
    output logic [2:0]           o_current_clip,
    output logic [7:0]           o_frame_number,
    output logic                 o_finished,
    output logic                 o_change_accepted,
    // configuration
    input  logic                 i_cfg_we,
    input  sas_pkg::t_cfg_index  i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import sas_pkg::*;

    localparam int POS_W  = 8 + FRAC_BITS;
    localparam int STEP_W = 32 - FRAC_BITS;
    localparam int SUM_W  = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
    localparam int INT_W  = SUM_W - FRAC_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_WRAP = 3'd5;
    localparam logic [2:0] ST_TEX  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    // configuration registers
    logic [15:0] r_frame_rate;
    logic [63:0] r_lengths;
    logic [7:0]  r_once_mask;
    logic [31:0] r_next_table;
    logic [63:0] r_tex_bases;
    logic [3:0]  r_clip_count;

    // sequencer state
    logic [2:0]       r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_clip, n_clip;
    logic [2:0]       r_fallback, n_fallback;
    logic             r_restart, n_restart;
    logic [7:0]       r_texture, n_texture;
    logic             r_accepted, n_accepted;
    logic [15:0]      r_delta, n_delta;
    logic [31:0]      r_prod;
    logic [SUM_W-1:0] r_sum;
    logic             r_out_valid;

    // remainder unit hookup
    logic        rem_start;
    logic [7:0]  rem_value;
    t_rem_status rem_status;
    logic        rem_running;

    // current clip view
    logic [7:0]       cur_len;
    logic             cur_once;
    logic [7:0]       cur_int;
    logic             cur_fin;
    logic [7:0]       cur_frame;
    logic             sel_ok;
    logic [3:0]       used_clips;
    logic [2:0]       top_clip;
    logic [2:0]       sel_clip;
    logic [3:0]       next_raw;
    logic [2:0]       chain_clip;
    logic [SUM_W-1:0] lim_ext;
    logic [POS_W-1:0] lim_pos;
    logic [POS_W-1:0] top_pos;
    logic [FRAC_BITS-1:0] sum_frac;
    logic             in_accept;
    logic             in_tex;

    assign cur_len   = clip_len(r_lengths, r_clip);
    assign cur_once  = clip_once(r_once_mask, r_clip);
    assign cur_int   = r_pos[POS_W-1:FRAC_BITS];
    assign cur_fin   = cur_once && (cur_len != 8'd0) && (cur_int == cur_len - 8'd1);
    assign cur_frame = (cur_len == 8'd0) ? 8'd0 :
                       (cur_int < cur_len) ? cur_int : cur_len - 8'd1;
    assign sel_ok    = !cur_once || cur_fin;

    // clip count clamping
    always_comb begin
        used_clips = r_clip_count;
        if (used_clips == 4'd0) begin
            used_clips = 4'd1;
        end
        if (used_clips > 4'(MAX_CLIPS)) begin
            used_clips = 4'(MAX_CLIPS);
        end
    end
    assign top_clip   = 3'(used_clips - 4'd1);
    assign sel_clip   = (i_clip_index > top_clip) ? top_clip : i_clip_index;
    assign next_raw   = clip_next(r_next_table, r_clip);
    assign chain_clip = next_raw[3] ? r_fallback :
                        ((next_raw[2:0] > top_clip) ? top_clip : next_raw[2:0]);

    // wrap and clamp limits of the current clip
    assign lim_pos  = {cur_len, {FRAC_BITS{1'b0}}};
    assign top_pos  = {cur_len - 8'd1, {FRAC_BITS{1'b0}}};
    assign lim_ext  = SUM_W'(lim_pos);
    assign sum_frac = r_sum[FRAC_BITS-1:0];

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_clip     = r_clip;
        n_fallback = r_fallback;
        n_restart  = r_restart;
        n_texture  = r_texture;
        n_accepted = r_accepted;
        n_delta    = r_delta;
        rem_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_accepted = 1'b0;
                    n_state    = ST_DONE;
                    if (i_kind == KIND_TICK) begin
                        if (cur_len == 8'd0) begin
                            n_state = ST_DONE;
                        end else if (cur_fin) begin
                            // chain to the next or default clip at frame 0
                            n_clip    = chain_clip;
                            n_pos     = '0;
                            n_texture = clip_base(r_tex_bases, chain_clip);
                        end else if (r_restart) begin
                            n_pos     = '0;
                            n_restart = 1'b0;
                            n_texture = clip_base(r_tex_bases, r_clip);
                        end else begin
                            n_delta = i_delta;
                            n_state = ST_MUL;
                        end
                    end else if ((i_kind == KIND_SEL_CUR) || (i_kind == KIND_SEL_DEF)) begin
                        if (sel_ok) begin
                            n_accepted = 1'b1;
                            if (i_kind == KIND_SEL_CUR) begin
                                n_clip    = sel_clip;
                                n_restart = 1'b1;
                            end else begin
                                n_fallback = sel_clip;
                            end
                        end
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = ST_TEX;
                if (cur_once) begin
                    n_pos = (r_sum > SUM_W'(top_pos)) ? top_pos : r_sum[POS_W-1:0];
                end else if (r_sum > lim_ext) begin
                    rem_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_pos = r_sum[POS_W-1:0];
                end
            end
            ST_DIV: begin
                if (rem_status.done) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                // exact multiple of the length stays at the full length
                if ((rem_value == 8'd0) && (sum_frac == '0)) begin
                    n_pos = lim_pos;
                end else begin
                    n_pos = {rem_value, sum_frac};
                end
                n_state = ST_TEX;
            end
            ST_TEX: begin
                n_texture = clip_base(r_tex_bases, r_clip) + cur_frame;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_clip       <= '0;
            r_fallback   <= '0;
            r_restart    <= 1'b0;
            r_texture    <= '0;
            r_accepted   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_frame_rate <= 16'd256;
            r_lengths    <= 64'h0101_0101_0101_0101;
            r_once_mask  <= '0;
            r_next_table <= 32'hFFFF_FFFF;
            r_tex_bases  <= '0;
            r_clip_count <= 4'd1;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_clip     <= n_clip;
            r_fallback <= n_fallback;
            r_restart  <= n_restart;
            r_texture  <= n_texture;
            r_accepted <= n_accepted;
            if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_RATE:   r_frame_rate <= i_cfg_data[15:0];
                    CFG_CLIP_LENGTHS: r_lengths    <= i_cfg_data;
                    CFG_ONCE_MASK:    r_once_mask  <= i_cfg_data[7:0];
                    CFG_NEXT_TABLE:   r_next_table <= i_cfg_data[31:0];
                    CFG_TEX_BASES:    r_tex_bases  <= i_cfg_data;
                    CFG_CLIP_COUNT:   r_clip_count <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // advance datapath: product then position sum
    always_ff @(posedge i_clk) begin
        r_delta <= n_delta;
        if (r_state == ST_MUL) begin
            r_prod <= r_frame_rate * r_delta;
        end
        if (r_state == ST_ADD) begin
            r_sum <= SUM_W'(r_pos) + SUM_W'(r_prod[31:FRAC_BITS]);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
            o_texture_index   <= r_texture;
            o_current_clip    <= r_clip;
            o_frame_number    <= cur_frame;
            o_finished        <= cur_fin;
            o_change_accepted <= r_accepted;
        end
    end

    assign o_out_valid = r_out_valid;

    // integer-part remainder for loop wrap
    sas_rem_unit #(
        .NUM_W (INT_W)
    ) u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rem_start),
        .i_num    (r_sum[SUM_W-1:FRAC_BITS]),
        .i_den    (cur_len),
        .o_rem    (rem_value),
        .o_status (rem_status)
    );

    // checks
    assign rem_running = rem_status.busy || rem_status.done;
    assign in_tex      = (r_state == ST_TEX);

`include "sprite_animation_sequencer_unit_macros.svh"

    `SAS_ASSERT_NEXT(a_accept_leaves_idle, in_accept, r_state != ST_IDLE, "accept kept idle")
    `SAS_ASSERT_NOW(a_div_running, r_state == ST_DIV, rem_running, "remainder not running")
    `SAS_ASSERT_NOW(a_rem_below_len, r_state == ST_WRAP, rem_value < cur_len, "bad remainder")
    `SAS_ASSERT_NOW(a_loop_in_range, in_tex && !cur_once, r_pos <= lim_pos, "loop overrun")
    `SAS_ASSERT_NOW(a_once_clamped, in_tex && cur_once, r_pos <= top_pos, "once overrun")

endmodule

@@ rtl/core/sas_rem_unit.sv @@
// bit-serial remainder of an integer frame count by a clip length
module sas_rem_unit #(
    parameter int NUM_W = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [7:0]            i_den,
    output logic [7:0]            o_rem,
    output sas_pkg::t_rem_status  o_status
);
    import sas_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [7:0]       r_rem;
    logic [7:0]       r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [8:0] trial;
    logic       fits;
    logic [8:0] diff;

    // one restoring step: shift in next numerator bit, subtract when it fits
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= fits ? diff[7:0] : trial[7:0];
        end
    end

    assign o_rem           = r_rem;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule
